/* rtl/core/htd_pkg.sv */
// Shared types and constants of the tree-walk prefix-code decoder.
package htd_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_SYMBOL     = 2'd0;
  localparam logic [1:0] ST_BAD_PATH   = 2'd1;
  localparam logic [1:0] ST_STORE_FULL = 2'd2;

  localparam int         CMDQ_DEPTH = 2;
  localparam logic [3:0] BYTE_BITS  = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DECODE,
    CMD_CLEAR,
    CMD_BAD_LEN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  data_byte;
    logic [3:0]  bit_count;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_LOAD_RD,
    S_DEC_RD,
    S_DEC,
    S_DEC_CHK,
    S_FLUSH
  } back_state_t;

endpackage

/* rtl/core/huffman_tree_decoder_unit.sv */
// Prefix-code decoder: a code tree in a node memory, loaded and walked bit by bit.
//
// Input channel (in_valid / in_stall): op 0 loads one code entry (symbol, code_bits,
// code_length), op 1 decodes the leading valid_bits of data_byte MSB first, op 2
// clears the tree. Output channel (out_valid / out_stall) carries decoded_symbol,
// status (symbol, invalid path, store full) and last on the final result of a
// transaction. Loads that succeed, clears and decodes that end mid-code give no result.
// Input transactions go into a two-entry command queue; the walker takes one at a time.
// A load goes through command pickup, then for each code bit either a new node or a read
// of a node already in the tree, then the leaf write and the close out.
// A decode goes through command pickup, a node read when resuming inside a code, then for
// each bit that reaches a node a read with registered data and the leaf check, or for a
// bit with no child an invalid-path result, then the end of bits and the close out.
// The walker's node memory serves one read or one write at a time.
// Each result is held until the next one of its transaction or the close out.
// Reset empties the tree and the queue at once; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the walker waits at
// its next result once it holds one back, and the queue keeps taking input until it is full.
module huffman_tree_decoder_unit #(
  parameter int MAX_NODES    = 512,
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  valid_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  decoded_symbol,
  output logic [1:0]  status,
  output logic        last
);

  logic          cmd_valid;
  logic          cmd_pop;
  htd_pkg::cmd_t cmd;

  htd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .data_byte   (data_byte),
    .valid_bits  (valid_bits),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  htd_back #(
    .MAX_NODES   (MAX_NODES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .decoded_symbol (decoded_symbol),
    .status         (status),
    .last           (last)
  );

endmodule

/* rtl/core/htd_front.sv */
// Input side: accepts transactions, classifies them and queues commands for the walker.
module htd_front #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [7:0]       symbol,
  input  logic [31:0]      code_bits,
  input  logic [5:0]       code_length,
  input  logic [7:0]       data_byte,
  input  logic [3:0]       valid_bits,
  output logic             cmd_valid,
  output htd_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  localparam int PTR_W = (htd_pkg::CMDQ_DEPTH > 1) ? $clog2(htd_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(htd_pkg::CMDQ_DEPTH + 1);

  htd_pkg::cmd_t cmd_q [htd_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  htd_pkg::cmd_t in_cmd;
  logic          keep;
  logic          len_bad;
  logic          push;

  assign len_bad = (code_length == 6'd0) || ({1'b0, code_length} > 7'(MAX_CODE_LEN));

  always_comb begin
    in_cmd.symbol      = symbol;
    in_cmd.code_bits   = code_bits;
    in_cmd.code_length = code_length;
    in_cmd.data_byte   = data_byte;
    in_cmd.bit_count   = (valid_bits > htd_pkg::BYTE_BITS) ? htd_pkg::BYTE_BITS : valid_bits;
    case (op)
      htd_pkg::OP_LOAD: begin
        in_cmd.kind = len_bad ? htd_pkg::CMD_BAD_LEN : htd_pkg::CMD_LOAD;
        keep        = 1'b1;
      end
      htd_pkg::OP_DECODE: begin
        // A byte with no valid bits produces nothing, so it never reaches the walker.
        in_cmd.kind = htd_pkg::CMD_DECODE;
        keep        = (valid_bits != 4'd0);
      end
      htd_pkg::OP_CLEAR: begin
        in_cmd.kind = htd_pkg::CMD_CLEAR;
        keep        = 1'b1;
      end
      default: begin
        in_cmd.kind = htd_pkg::CMD_CLEAR;
        keep        = 1'b0;
      end
    endcase
  end

  assign in_stall  = (count == CNT_W'(htd_pkg::CMDQ_DEPTH));
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count != '0);
  assign cmd       = cmd_q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !cmd_pop) begin
      count_next = count + CNT_W'(1);
    end else if (!push && cmd_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(htd_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(htd_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/core/htd_back.sv */
// Walker: node memory, load and decode sequencer, and the result output register.
module htd_back #(
  parameter int MAX_NODES   = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  htd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    decoded_symbol,
  output logic [1:0]    status,
  output logic          last
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int FW = NW + 1;
  localparam int EW = 1 + SYMBOL_BITS + 2 * NW;

  htd_pkg::back_state_t state;
  htd_pkg::back_state_t state_next;

  // Node memory; entry 0 is unused because the root lives in registers.
  logic [EW-1:0] node_mem [MAX_NODES];
  logic [EW-1:0] rdata;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [NW-1:0] mem_raddr;

  logic [NW-1:0]          cur_idx, cur_idx_next;
  logic                   cur_leaf, cur_leaf_next;
  logic [SYMBOL_BITS-1:0] cur_sym, cur_sym_next;
  logic [NW-1:0]          cur_kid0, cur_kid0_next;
  logic [NW-1:0]          cur_kid1, cur_kid1_next;
  logic [NW-1:0]          nxt_idx, nxt_idx_next;
  logic [5:0]             step, step_next;
  logic [31:0]            code, code_next;
  logic [SYMBOL_BITS-1:0] lsym, lsym_next;
  logic [7:0]             dbits, dbits_next;
  logic [3:0]             dcnt, dcnt_next;
  logic [NW-1:0]          walk, walk_next;
  logic [FW-1:0]          next_free, next_free_next;
  logic [NW-1:0]          root_kid0, root_kid0_next;
  logic [NW-1:0]          root_kid1, root_kid1_next;
  logic                   pend_valid, pend_valid_next;
  logic [7:0]             pend_sym, pend_sym_next;
  logic [1:0]             pend_status, pend_status_next;
  logic                   out_valid_next;
  logic [7:0]             out_sym_next;
  logic [1:0]             out_status_next;
  logic                   out_last_next;
  logic                   out_load;

  logic       res_new;
  logic [7:0] res_sym;
  logic [1:0] res_status;

  logic                   out_free;
  logic                   room;
  logic [5:0]             load_pos;
  logic                   load_b;
  logic [NW-1:0]          load_nxt;
  logic                   store_full;
  logic [NW-1:0]          new_idx;
  logic [NW-1:0]          dec_nxt;
  logic                   rd_leaf;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [NW-1:0]          rd_kid0;
  logic [NW-1:0]          rd_kid1;
  logic [SYMBOL_BITS+7:0] rd_sym_wide;
  logic [SYMBOL_BITS+7:0] in_sym_wide;

  assign out_free   = !out_valid || !out_stall;
  assign room       = !pend_valid || out_free;
  assign load_pos   = step - 6'd1;
  assign load_b     = !load_pos[5] && code[load_pos[4:0]];
  assign load_nxt   = load_b ? cur_kid1 : cur_kid0;
  assign store_full = (next_free >= FW'(MAX_NODES));
  assign new_idx    = next_free[NW-1:0];
  assign dec_nxt    = dbits[7] ? cur_kid1 : cur_kid0;

  assign rd_kid0     = rdata[NW-1:0];
  assign rd_kid1     = rdata[2*NW-1:NW];
  assign rd_sym      = rdata[2*NW +: SYMBOL_BITS];
  assign rd_leaf     = rdata[EW-1];
  assign rd_sym_wide = {8'd0, rd_sym};
  assign in_sym_wide = {{SYMBOL_BITS{1'b0}}, cmd.symbol};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      htd_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            htd_pkg::CMD_CLEAR:   state_next = htd_pkg::S_IDLE;
            htd_pkg::CMD_BAD_LEN: state_next = htd_pkg::S_FLUSH;
            htd_pkg::CMD_LOAD:    state_next = htd_pkg::S_LOAD;
            htd_pkg::CMD_DECODE: begin
              state_next = (walk == '0) ? htd_pkg::S_DEC : htd_pkg::S_DEC_RD;
            end
            default: state_next = htd_pkg::S_IDLE;
          endcase
        end
      end
      htd_pkg::S_LOAD: begin
        if (step == 6'd0) begin
          state_next = htd_pkg::S_FLUSH;
        end else if (load_nxt != '0) begin
          state_next = htd_pkg::S_LOAD_RD;
        end else if (store_full) begin
          state_next = htd_pkg::S_FLUSH;
        end
      end
      htd_pkg::S_LOAD_RD: state_next = htd_pkg::S_LOAD;
      htd_pkg::S_DEC_RD:  state_next = htd_pkg::S_DEC;
      htd_pkg::S_DEC: begin
        if (dcnt == 4'd0) begin
          state_next = htd_pkg::S_FLUSH;
        end else if (dec_nxt != '0) begin
          state_next = htd_pkg::S_DEC_CHK;
        end
      end
      htd_pkg::S_DEC_CHK: begin
        if (!rd_leaf || room) begin
          state_next = htd_pkg::S_DEC;
        end
      end
      htd_pkg::S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = htd_pkg::S_IDLE;
        end
      end
      default: state_next = htd_pkg::S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    cmd_pop          = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = cur_idx;
    mem_wdata        = {cur_leaf, cur_sym, cur_kid1, cur_kid0};
    mem_re           = 1'b0;
    mem_raddr        = dec_nxt;
    cur_idx_next     = cur_idx;
    cur_leaf_next    = cur_leaf;
    cur_sym_next     = cur_sym;
    cur_kid0_next    = cur_kid0;
    cur_kid1_next    = cur_kid1;
    nxt_idx_next     = nxt_idx;
    step_next        = step;
    code_next        = code;
    lsym_next        = lsym;
    dbits_next       = dbits;
    dcnt_next        = dcnt;
    walk_next        = walk;
    next_free_next   = next_free;
    root_kid0_next   = root_kid0;
    root_kid1_next   = root_kid1;
    pend_valid_next  = pend_valid;
    pend_sym_next    = pend_sym;
    pend_status_next = pend_status;
    out_load         = 1'b0;
    out_sym_next     = decoded_symbol;
    out_status_next  = status;
    out_last_next    = last;
    res_new          = 1'b0;
    res_sym          = 8'd0;
    res_status       = htd_pkg::ST_SYMBOL;

    case (state)
      htd_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            htd_pkg::CMD_CLEAR: begin
              root_kid0_next = '0;
              root_kid1_next = '0;
              next_free_next = FW'(1);
              walk_next      = '0;
            end
            htd_pkg::CMD_BAD_LEN: begin
              res_new    = 1'b1;
              res_status = htd_pkg::ST_BAD_PATH;
            end
            htd_pkg::CMD_LOAD: begin
              cur_idx_next  = '0;
              cur_leaf_next = 1'b0;
              cur_sym_next  = '0;
              cur_kid0_next = root_kid0;
              cur_kid1_next = root_kid1;
              step_next     = cmd.code_length;
              code_next     = cmd.code_bits;
              lsym_next     = in_sym_wide[SYMBOL_BITS-1:0];
            end
            htd_pkg::CMD_DECODE: begin
              dbits_next = cmd.data_byte;
              dcnt_next  = cmd.bit_count;
              if (walk == '0) begin
                cur_kid0_next = root_kid0;
                cur_kid1_next = root_kid1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = walk;
              end
            end
            default: ;
          endcase
        end
      end
      htd_pkg::S_LOAD: begin
        if (step == 6'd0) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, lsym, cur_kid1, cur_kid0};
        end else if (load_nxt != '0) begin
          mem_re       = 1'b1;
          mem_raddr    = load_nxt;
          cur_idx_next = load_nxt;
          step_next    = step - 6'd1;
        end else if (store_full) begin
          // A freshly allocated node must reach memory even though no leaf is marked.
          mem_we     = (cur_idx != '0);
          res_new    = 1'b1;
          res_status = htd_pkg::ST_STORE_FULL;
        end else begin
          next_free_next = next_free + FW'(1);
          if (cur_idx == '0) begin
            if (load_b) begin
              root_kid1_next = new_idx;
            end else begin
              root_kid0_next = new_idx;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = load_b ? {cur_leaf, cur_sym, new_idx, cur_kid0}
                               : {cur_leaf, cur_sym, cur_kid1, new_idx};
          end
          cur_idx_next  = new_idx;
          cur_leaf_next = 1'b0;
          cur_sym_next  = '0;
          cur_kid0_next = '0;
          cur_kid1_next = '0;
          step_next     = step - 6'd1;
        end
      end
      htd_pkg::S_LOAD_RD, htd_pkg::S_DEC_RD: begin
        cur_leaf_next = rd_leaf;
        cur_sym_next  = rd_sym;
        cur_kid0_next = rd_kid0;
        cur_kid1_next = rd_kid1;
      end
      htd_pkg::S_DEC: begin
        if (dcnt != 4'd0) begin
          if (dec_nxt == '0) begin
            if (room) begin
              res_new       = 1'b1;
              res_status    = htd_pkg::ST_BAD_PATH;
              walk_next     = '0;
              cur_kid0_next = root_kid0;
              cur_kid1_next = root_kid1;
              dbits_next    = {dbits[6:0], 1'b0};
              dcnt_next     = dcnt - 4'd1;
            end
          end else begin
            mem_re       = 1'b1;
            mem_raddr    = dec_nxt;
            nxt_idx_next = dec_nxt;
            dbits_next   = {dbits[6:0], 1'b0};
            dcnt_next    = dcnt - 4'd1;
          end
        end
      end
      htd_pkg::S_DEC_CHK: begin
        if (rd_leaf) begin
          if (room) begin
            res_new       = 1'b1;
            res_sym       = rd_sym_wide[7:0];
            res_status    = htd_pkg::ST_SYMBOL;
            walk_next     = '0;
            cur_kid0_next = root_kid0;
            cur_kid1_next = root_kid1;
          end
        end else begin
          walk_next     = nxt_idx;
          cur_kid0_next = rd_kid0;
          cur_kid1_next = rd_kid1;
        end
      end
      htd_pkg::S_FLUSH: begin
        if (pend_valid && out_free) begin
          out_load        = 1'b1;
          out_sym_next    = pend_sym;
          out_status_next = pend_status;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase

    // A result is held back in a pending register so that the last one of a transaction can be flagged.
    if (res_new) begin
      if (pend_valid) begin
        out_load        = 1'b1;
        out_sym_next    = pend_sym;
        out_status_next = pend_status;
        out_last_next   = 1'b0;
      end
      pend_valid_next  = 1'b1;
      pend_sym_next    = res_sym;
      pend_status_next = res_status;
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htd_pkg::S_IDLE;
      walk       <= '0;
      next_free  <= FW'(1);
      root_kid0  <= '0;
      root_kid1  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      walk       <= walk_next;
      next_free  <= next_free_next;
      root_kid0  <= root_kid0_next;
      root_kid1  <= root_kid1_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx        <= cur_idx_next;
    cur_leaf       <= cur_leaf_next;
    cur_sym        <= cur_sym_next;
    cur_kid0       <= cur_kid0_next;
    cur_kid1       <= cur_kid1_next;
    nxt_idx        <= nxt_idx_next;
    step           <= step_next;
    code           <= code_next;
    lsym           <= lsym_next;
    dbits          <= dbits_next;
    dcnt           <= dcnt_next;
    pend_sym       <= pend_sym_next;
    pend_status    <= pend_status_next;
    decoded_symbol <= out_sym_next;
    status         <= out_status_next;
    last           <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= node_mem[mem_raddr];
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FW'(MAX_NODES))
    else $error("allocation pointer ran past the node store");

  a_walk_allocated: assert property (@(posedge clk) disable iff (rst)
    {1'b0, walk} < next_free)
    else $error("walk position points at an unallocated node");

  a_root_not_in_mem: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr != '0))
    else $error("node memory write aimed at the root");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while a result waits");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == htd_pkg::S_IDLE) |-> !pend_valid)
    else $error("held result left behind at end of transaction");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the tree-walk prefix-code decoder unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int         TREE_NODES = 512;
  localparam int         CODE_MAX   = 32;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  data_byte;
    logic [3:0]  valid_bits;
    bit          drain;
  } tree_item_t;

  typedef struct {
    logic [7:0] sym;
    logic [1:0] stat;
    logic       fin;
  } due_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = htd_pkg::OP_CLEAR;
  logic [7:0]  symbol = '0;
  logic [31:0] code_bits = '0;
  logic [5:0]  code_length = '0;
  logic [7:0]  data_byte = '0;
  logic [3:0]  valid_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  decoded_symbol;
  logic [1:0]  status;
  logic        last;

  huffman_tree_decoder_unit #(
    .MAX_NODES   (TREE_NODES),
    .MAX_CODE_LEN(CODE_MAX),
    .SYMBOL_BITS (8)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .symbol        (symbol),
    .code_bits     (code_bits),
    .code_length   (code_length),
    .data_byte     (data_byte),
    .valid_bits    (valid_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .decoded_symbol(decoded_symbol),
    .status        (status),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted tree contents and walk state.
  logic       tree_leaf [TREE_NODES];
  logic [7:0] tree_sym  [TREE_NODES];
  logic [8:0] tree_kid  [TREE_NODES][2];
  int         next_free;
  int         walk_at;

  tree_item_t items_pending[$];
  due_t       symbols_due[$];
  int         stim_count;
  bit         drain_next;
  int         errors;
  int         items_sent;
  int         seen_symbol, seen_bad, seen_full;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic empty_node(input int idx);
    tree_leaf[idx]   = 1'b0;
    tree_sym[idx]    = '0;
    tree_kid[idx][0] = '0;
    tree_kid[idx][1] = '0;
  endtask

  task automatic clear_tree();
    empty_node(0);
    next_free = 1;
    walk_at   = 0;
  endtask

  // Applies one accepted transaction to the predicted tree and queues its results.
  task automatic predict_results(input tree_item_t it);
    int   i, cur, nxt, len, n;
    logic b;
    bit   full;
    due_t found[$];
    full = 0;
    case (it.op)
      htd_pkg::OP_LOAD: begin
        len = int'(it.code_length);
        if (len == 0 || len > CODE_MAX) begin
          found.insert(found.size(), due_t'{8'd0, htd_pkg::ST_BAD_PATH, 1'b1});
        end else begin
          cur = 0;
          for (i = len; i > 0 && !full; i--) begin
            b   = it.code_bits[i-1];
            nxt = int'(tree_kid[cur][b]);
            if (nxt == 0) begin
              if (next_free >= TREE_NODES) begin
                full = 1;
              end else begin
                nxt = next_free;
                next_free++;
                empty_node(nxt);
                tree_kid[cur][b] = nxt[8:0];
              end
            end
            if (!full) cur = nxt;
          end
          if (full) begin
            found.insert(found.size(), due_t'{8'd0, htd_pkg::ST_STORE_FULL, 1'b1});
          end else begin
            tree_leaf[cur] = 1'b1;
            tree_sym[cur]  = it.symbol;
          end
        end
      end
      htd_pkg::OP_DECODE: begin
        n = (it.valid_bits > 4'd8) ? 8 : int'(it.valid_bits);
        for (i = 0; i < n; i++) begin
          b   = it.data_byte[7-i];
          nxt = int'(tree_kid[walk_at][b]);
          if (nxt == 0) begin
            found.insert(found.size(), due_t'{8'd0, htd_pkg::ST_BAD_PATH, 1'b0});
            walk_at = 0;
          end else if (tree_leaf[nxt]) begin
            found.insert(found.size(), due_t'{tree_sym[nxt], htd_pkg::ST_SYMBOL, 1'b0});
            walk_at = 0;
          end else begin
            walk_at = nxt;
          end
        end
        if (found.size() > 0) found[found.size()-1].fin = 1'b1;
      end
      htd_pkg::OP_CLEAR: clear_tree();
      default: ;
    endcase
    foreach (found[k]) symbols_due.insert(symbols_due.size(), found[k]);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queues one transaction; unused fields carry random values.
  task automatic add_item(input logic [1:0] o, input logic [7:0] sym, input logic [31:0] bits,
                          input logic [5:0] len, input logic [7:0] byte_in,
                          input logic [3:0] vb);
    tree_item_t it;
    it.op          = o;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    it.data_byte   = byte_in;
    it.valid_bits  = vb;
    it.drain       = drain_next;
    drain_next     = 0;
    items_pending.insert(items_pending.size(), it);
    stim_count++;
  endtask

  task automatic add_load(input logic [7:0] sym, input logic [31:0] bits, input int len);
    add_item(htd_pkg::OP_LOAD, sym, bits, len[5:0], 8'($urandom()), 4'($urandom()));
  endtask

  task automatic add_decode(input logic [7:0] byte_in, input int vb);
    add_item(htd_pkg::OP_DECODE, 8'($urandom()), $urandom(), 6'($urandom()), byte_in,
             vb[3:0]);
  endtask

  task automatic add_plain(input logic [1:0] o);
    add_item(o, 8'($urandom()), $urandom(), 6'($urandom()), 8'($urandom()),
             4'($urandom()));
  endtask

  // Builds a random complete prefix code, loads it and sends an encoded stream.
  task automatic add_code_set();
    logic [31:0] cw_bits[$];
    int          cw_len[$];
    bit          stream[$];
    int          n, j, l, m, take, vb;
    logic [31:0] b;
    logic [7:0]  byte_out;
    if ($urandom_range(0, 9) < 8) add_plain(htd_pkg::OP_CLEAR);
    cw_bits = '{32'd0, 32'd1};
    cw_len  = '{1, 1};
    n = $urandom_range(2, 12);
    while (cw_bits.size() < n) begin
      j = ($urandom_range(0, 9) < 3) ? cw_bits.size() - 1 : $urandom_range(0, cw_bits.size() - 1);
      b = cw_bits[j];
      l = cw_len[j];
      cw_bits[j] = b << 1;
      cw_len[j]  = l + 1;
      cw_bits.insert(cw_bits.size(), (b << 1) | 32'd1);
      cw_len.insert(cw_len.size(), l + 1);
    end
    for (j = cw_bits.size() - 1; j > 0; j--) begin
      m = $urandom_range(0, j);
      b = cw_bits[j]; cw_bits[j] = cw_bits[m]; cw_bits[m] = b;
      l = cw_len[j];  cw_len[j]  = cw_len[m];  cw_len[m]  = l;
    end
    foreach (cw_bits[k])
      add_load(8'($urandom()), ($urandom() << cw_len[k]) | cw_bits[k], cw_len[k]);
    m = $urandom_range(5, 20);
    repeat (m) begin
      j = $urandom_range(0, cw_bits.size() - 1);
      for (l = cw_len[j] - 1; l >= 0; l--) stream.insert(stream.size(), cw_bits[j][l]);
    end
    while (stream.size() > 0) begin
      if ($urandom_range(0, 19) == 0) add_decode(8'($urandom()), 0);
      take = $urandom_range(1, 8);
      if (take > stream.size()) take = stream.size();
      byte_out = 8'($urandom());
      for (l = 0; l < take; l++) byte_out[7-l] = stream.pop_front();
      vb = take;
      if (take == 8 && $urandom_range(0, 9) == 0) vb = $urandom_range(9, 15);
      add_decode(byte_out, vb);
    end
  endtask

  // Clears the tree, loads long random codes until the node store runs out, then decodes three random bytes.
  task automatic add_store_fill();
    drain_next = 1;
    add_plain(htd_pkg::OP_CLEAR);
    repeat (24) add_load(8'($urandom()), $urandom(), CODE_MAX);
    repeat (3) add_decode(8'($urandom()), $urandom_range(1, 8));
  endtask

  // Input side: one transaction on the pins at a time, random gaps between them.
  always @(posedge clk) begin : in_driver
    tree_item_t cur_item;
    int         gap_left;
    int         send_burst;
    bit         busy, go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      go   = 0;
      if (in_valid && !in_stall) begin
        predict_results(cur_item);
        items_sent++;
        busy = 0;
        if (send_burst > 0) begin
          send_burst--;
          gap_left = 0;
        end else begin
          gap_left = idle_len();
          if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 80);
        end
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_pending.size() > 0 &&
                     !(items_pending[0].drain && symbols_due.size() != 0)) begin
          cur_item = items_pending.pop_front();
          go = 1;
        end
      end
      in_valid <= busy || go;
      if (go) begin
        op          <= cur_item.op;
        symbol      <= cur_item.symbol;
        code_bits   <= cur_item.code_bits;
        code_length <= cur_item.code_length;
        data_byte   <= cur_item.data_byte;
        valid_bits  <= cur_item.valid_bits;
      end
    end
  end

  // Output side: checks each result transaction and stalls at random.
  always @(posedge clk) begin : out_monitor
    due_t e;
    int   stall_left;
    int   stall_burst;
    int   hold;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: sym %0h status %0d last %0b",
                                    decoded_symbol, status, last));
        end else begin
          e = symbols_due.pop_front();
          case (e.stat)
            htd_pkg::ST_SYMBOL:     seen_symbol++;
            htd_pkg::ST_BAD_PATH:   seen_bad++;
            htd_pkg::ST_STORE_FULL: seen_full++;
            default: ;
          endcase
          if (decoded_symbol !== e.sym)
            report_mismatch($sformatf("decoded_symbol %0h, expected %0h", decoded_symbol, e.sym));
          if (status !== e.stat)
            report_mismatch($sformatf("status %0d, expected %0d", status, e.stat));
          if (last !== e.fin)
            report_mismatch($sformatf("last %0b, expected %0b", last, e.fin));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b0;
      end else begin
        hold = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (hold > 0) begin
          stall_left = hold - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
        if ($urandom_range(0, 59) == 0) stall_burst = $urandom_range(20, 80);
      end
    end
  end

  initial begin
    int r;
    for (int i = 0; i < TREE_NODES; i++) empty_node(i);
    clear_tree();

    // Directed part: code extremes, bad lengths, relabeling and walks through leaves.
    add_plain(htd_pkg::OP_CLEAR);
    add_load(8'hFF, 32'hFFFF_FFFE, 1);
    add_load(8'h00, 32'hFFFF_FFFF, CODE_MAX);
    add_load(8'hA5, 32'h0000_0002, 2);
    add_load(8'h12, 32'h0000_0000, 0);
    add_load(8'h34, 32'hFFFF_FFFF, 33);
    add_load(8'h56, 32'h5555_5555, 63);
    add_decode(8'h00, 1);
    add_decode(8'hFF, 8);
    add_decode(8'h00, 8);
    add_decode(8'hFF, 0);
    add_decode(8'h80, 15);
    add_load(8'h3C, 32'hFFFF_FFF1, 2);
    add_load(8'h11, 32'h0000_0000, 1);
    add_decode(8'h40, 2);
    add_plain(OP_UNUSED);
    add_decode(8'h80, 2);
    add_plain(htd_pkg::OP_CLEAR);
    add_decode(8'h40, 4);
    add_load(8'h77, 32'h0000_0001, 1);
    add_decode(8'hC0, 9);

    // Random part, mostly loaded codes followed by streams that use them.
    drain_next = 1;
    add_store_fill();
    while (stim_count < 480) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        add_code_set();
      end else if (r < 70) begin
        repeat ($urandom_range(1, 5)) add_decode(8'($urandom()), $urandom_range(0, 15));
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4))
          add_load(8'($urandom()), $urandom(),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32));
      end else if (r < 86) begin
        add_plain(($urandom_range(0, 1) == 0) ? OP_UNUSED : htd_pkg::OP_CLEAR);
      end else if (r < 88) begin
        add_store_fill();
      end else begin
        drain_next = 1;
        repeat ($urandom_range(1, 3)) add_decode(8'($urandom()), $urandom_range(1, 8));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (items_pending.size() != 0 || in_valid) @(posedge clk);
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d transactions: code loads, decode bytes, clears and unused ops.",
             items_sent);
    $display("Checked %0d symbols, %0d invalid paths and %0d store-full results.",
             seen_symbol, seen_bad, seen_full);
    if (errors == 0) begin
      $display("huffman_tree_decoder_unit: match");
    end else begin
      $display("huffman_tree_decoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out with %0d items and %0d results outstanding.",
             items_pending.size(), symbols_due.size());
    $display("huffman_tree_decoder_unit: mismatch");
    $finish;
  end

endmodule
